// ===== hdl/tsli_pkg.sv =====
`default_nettype none
package tsli_pkg;

    typedef struct packed {
        logic        new_run;
        logic [31:0] sample_value;
        logic [31:0] current_time;
    } t_item;

    typedef struct packed {
        logic busy;
        logic out_load;
    } t_eng_status;

    localparam int QUEUE_DEPTH = 2;
    localparam int MUL_STEPS   = 33;
    localparam int DIV_STEPS   = 64;
    localparam int STEP_W      = 7;

endpackage
`default_nettype wire

// ===== hdl/tsli_queue.sv =====
`default_nettype none
module tsli_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  tsli_pkg::t_item     i_item,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_valid,
    output tsli_pkg::t_item     o_item
);
    tsli_pkg::t_item r_mem [tsli_pkg::QUEUE_DEPTH];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'(tsli_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/tsli_engine.sv =====
`default_nettype none
module tsli_engine #(
    parameter int RING_DEPTH = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire  [31:0]            i_cfg_wr_data,
    input  wire                    i_item_valid,
    input  tsli_pkg::t_item        i_item,
    output logic                   o_item_pop,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [31:0]            o_lagged_value,
    output logic                   o_interpolated,
    output logic                   o_overflow,
    output tsli_pkg::t_eng_status  o_status
);
    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_LAGT = 11'b00000000010,
        S_CHK  = 11'b00000000100,
        S_SUCC = 11'b00000001000,
        S_TEST = 11'b00000010000,
        S_V0   = 11'b00000100000,
        S_V1   = 11'b00001000000,
        S_V2   = 11'b00010000000,
        S_MUL  = 11'b00100000000,
        S_DIV  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == IW'(RING_DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    logic [31:0] time_mem  [RING_DEPTH];
    logic [31:0] value_mem [RING_DEPTH];

    t_state r_state, n_state;
    logic [31:0] r_lag_amt;
    logic [IW-1:0] r_lag, n_lag, r_newest, n_newest;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_newest_time, n_newest_time;
    logic [31:0] r_t, n_t, r_t0, n_t0, r_t1, n_t1, r_v0, n_v0;
    logic [31:0] r_res, n_res;
    logic r_interp, n_interp, r_ovf, n_ovf, r_elig, n_elig, r_neg, n_neg;
    logic [32:0] r_mag, n_mag;
    logic [63:0] r_prod, n_prod;
    logic [32:0] r_rem, n_rem;
    logic [tsli_pkg::STEP_W-1:0] r_step, n_step;
    logic r_out_valid;
    logic [31:0] r_out_val;
    logic r_out_interp, r_out_ovf;

    logic [31:0] rd_t, rd_v;
    logic [IW-1:0] taddr, vaddr, waddr;
    logic t_we, v_we;
    logic [31:0] wt, wv;

    logic slot_free, load;
    logic [CW-1:0] cnt_eff;
    logic [31:0] target, num, den;
    logic [32:0] dv, rem_sh;
    logic [31:0] qlow;

    assign slot_free = !r_out_valid || i_ready;
    assign load      = (r_state == S_OUT) && slot_free;
    assign target    = r_t - r_lag_amt;
    assign num       = target - r_t0;
    assign den       = r_t1 - r_t0;
    assign dv        = {rd_v[31], rd_v} - {r_v0[31], r_v0};
    assign rem_sh    = {r_rem[31:0], r_prod[63]};
    assign qlow      = r_prod[31:0];

    always_comb begin
        n_state = r_state;
        n_lag = r_lag;
        n_newest = r_newest;
        n_count = r_count;
        n_newest_time = r_newest_time;
        n_t = r_t;
        n_t0 = r_t0;
        n_t1 = r_t1;
        n_v0 = r_v0;
        n_res = r_res;
        n_interp = r_interp;
        n_ovf = r_ovf;
        n_elig = r_elig;
        n_neg = r_neg;
        n_mag = r_mag;
        n_prod = r_prod;
        n_rem = r_rem;
        n_step = r_step;
        o_item_pop = 1'b0;
        taddr = r_lag;
        vaddr = r_lag;
        waddr = r_newest;
        t_we = 1'b0;
        v_we = 1'b0;
        wt = i_item.current_time;
        wv = i_item.sample_value;
        cnt_eff = i_item.new_run ? '0 : r_count;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_t = i_item.current_time;
                    n_interp = 1'b0;
                    n_ovf = 1'b0;
                    n_elig = 1'b0;
                    if (cnt_eff == '0) begin
                        waddr = '0;
                        t_we = 1'b1;
                        v_we = 1'b1;
                        n_lag = '0;
                        n_newest = '0;
                        n_count = CW'(1);
                        n_newest_time = i_item.current_time;
                        n_res = i_item.sample_value;
                        n_state = S_OUT;
                    end else if (i_item.current_time == r_newest_time) begin
                        v_we = 1'b1;
                        n_state = S_LAGT;
                    end else if (i_item.current_time > r_newest_time) begin
                        if (r_count >= CW'(RING_DEPTH)) begin
                            n_lag = ring_next(r_lag);
                            n_ovf = 1'b1;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                        waddr = ring_next(r_newest);
                        t_we = 1'b1;
                        v_we = 1'b1;
                        n_newest = ring_next(r_newest);
                        n_newest_time = i_item.current_time;
                        n_state = S_LAGT;
                    end else begin
                        n_state = S_V0;
                    end
                end
            end
            S_LAGT: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_t0 = rd_t;
                if ((r_t - rd_t) < r_lag_amt || r_lag == r_newest) begin
                    n_state = S_V0;
                end else begin
                    n_state = S_SUCC;
                end
            end
            S_SUCC: begin
                taddr = ring_next(r_lag);
                n_state = S_TEST;
            end
            S_TEST: begin
                if ((r_t - rd_t) >= r_lag_amt) begin
                    n_lag = ring_next(r_lag);
                    n_count = r_count - CW'(1);
                    n_t0 = rd_t;
                    n_state = (ring_next(r_lag) == r_newest) ? S_V0 : S_SUCC;
                end else begin
                    n_t1 = rd_t;
                    n_elig = 1'b1;
                    n_state = S_V0;
                end
            end
            S_V0: begin
                n_state = S_V1;
            end
            S_V1: begin
                n_v0 = rd_v;
                vaddr = ring_next(r_lag);
                n_state = S_V2;
            end
            S_V2: begin
                n_res = r_v0;
                n_neg = dv[32];
                n_mag = dv[32] ? (33'd0 - dv) : dv;
                n_prod = '0;
                n_step = '0;
                if (r_elig && target > r_t0 && den != 32'd0 && num < den) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                n_prod = {r_prod[62:0], 1'b0} + (r_mag[32] ? {32'd0, num} : 64'd0);
                n_mag = {r_mag[31:0], 1'b0};
                n_step = r_step + tsli_pkg::STEP_W'(1);
                if (r_step == tsli_pkg::STEP_W'(tsli_pkg::MUL_STEPS - 1)) begin
                    n_step = '0;
                    n_rem = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, den}) begin
                    n_rem = rem_sh - {1'b0, den};
                    n_prod = {r_prod[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_prod = {r_prod[62:0], 1'b0};
                end
                n_step = r_step + tsli_pkg::STEP_W'(1);
                if (r_step == tsli_pkg::STEP_W'(tsli_pkg::DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                    n_interp = 1'b1;
                end
            end
            S_OUT: begin
                if (r_interp && r_state == S_OUT && r_step != '0) begin
                    n_res = r_neg ? (r_v0 - qlow) : (r_v0 + qlow);
                    n_step = '0;
                end else if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lag_amt <= '0;
            r_lag <= '0;
            r_newest <= '0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lag <= n_lag;
            r_newest <= n_newest;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                r_lag_amt <= i_cfg_wr_data;
            end
            if (load && !(r_interp && r_step != '0)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest_time <= n_newest_time;
        r_t <= n_t;
        r_t0 <= n_t0;
        r_t1 <= n_t1;
        r_v0 <= n_v0;
        r_res <= n_res;
        r_interp <= n_interp;
        r_ovf <= n_ovf;
        r_elig <= n_elig;
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_prod <= n_prod;
        r_rem <= n_rem;
        r_step <= n_step;
        if (load && !(r_interp && r_step != '0)) begin
            r_out_val <= r_res;
            r_out_interp <= r_interp;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            time_mem[waddr] <= wt;
        end
        if (v_we) begin
            value_mem[waddr] <= wv;
        end
        rd_t <= time_mem[taddr];
        rd_v <= value_mem[vaddr];
    end

    assign o_valid = r_out_valid;
    assign o_lagged_value = r_out_val;
    assign o_interpolated = r_out_interp;
    assign o_overflow = r_out_ovf;
    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.out_load = load && !(r_interp && r_step != '0);
endmodule
`default_nettype wire

// ===== hdl/timestamped_lag_line_interp.sv =====
// Items are handled one at a time; interpolated results also pass through the back-end
// sequencer (33-step shift-add multiply, 64-step restoring divide).
// Throughput: a new item is taken only after the last result has been loaded;
// a 2-entry input queue and the output register let both sides stall independently.
// Reset: synchronous active-low; clears lag register, ring pointers, count, valids.
`default_nettype none
module timestamped_lag_line_interp #(
    parameter int RING_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [31:0] i_cfg_wr_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,  // current_time, sample_value
    input  wire         i_s_axis_tuser,  // new_run
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // lagged_value
    output logic [1:0]  o_m_axis_tuser   // interpolated, overflow
);
    tsli_pkg::t_item in_item, head;
    tsli_pkg::t_eng_status st;
    logic full, head_valid, pop, accept;

    assign in_item.current_time = i_s_axis_tdata[31:0];
    assign in_item.sample_value = i_s_axis_tdata[63:32];
    assign in_item.new_run      = i_s_axis_tuser;
    assign o_s_axis_tready      = !full;
    assign accept               = i_s_axis_tvalid && !full;

    tsli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head)
    );

    tsli_engine #(.RING_DEPTH(RING_DEPTH)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_item_valid   (head_valid),
        .i_item         (head),
        .o_item_pop     (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_lagged_value (o_m_axis_tdata),
        .o_interpolated (o_m_axis_tuser[0]),
        .o_overflow     (o_m_axis_tuser[1]),
        .o_status       (st)
    );

`ifndef SYNTH
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid) else $error("output valid after reset");
    a_rise_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(st.busy && st.out_load))
        else $error("result without engine load");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> st.busy) else $error("popped item not processed");
`endif
endmodule
`default_nettype wire

// ===== verif/timestamped_lag_line_interp_tb.sv =====
`default_nettype none

class lag_line_scoreboard;
    typedef struct {
        bit [31:0] value;
        bit        interp;
        bit        ovf;
    } lag_result_t;

    bit [31:0]   lag_ticks;
    bit [31:0]   time_ring [64];
    bit [31:0]   value_ring [64];
    bit [5:0]    oldest_idx;
    bit [5:0]    newest_idx;
    int          fill;
    lag_result_t pending_q[$];
    int          errors;
    int          n_checked;
    int          n_interp;
    int          n_ovf;

    function new();
        lag_ticks  = 0;
        oldest_idx = 0;
        newest_idx = 0;
        fill       = 0;
        errors     = 0;
        n_checked  = 0;
        n_interp   = 0;
        n_ovf      = 0;
    endfunction

    function int pending();
        return pending_q.size();
    endfunction

    // work out the lagged sample for one accepted transfer
    function void note_input(bit [31:0] t, bit [31:0] v, bit fresh);
        lag_result_t r;
        bit          upd;
        bit [31:0]   target, t0;
        bit [5:0]    succ;
        bit [63:0]   num, den, mag, q;
        longint      v0, v1, dv;
        r   = '{0, 0, 0};
        upd = 0;
        if (fresh) begin
            fill = 0;
            oldest_idx = 0;
            newest_idx = 0;
        end
        if (fill == 0) begin
            oldest_idx = 0;
            newest_idx = 0;
            time_ring[0] = t;
            value_ring[0] = v;
            fill = 1;
        end else if (t == time_ring[newest_idx]) begin
            value_ring[newest_idx] = v;
            upd = 1;
        end else if (t > time_ring[newest_idx]) begin
            if (fill >= 64) begin
                oldest_idx = oldest_idx + 1;
                fill--;
                r.ovf = 1;
            end
            newest_idx = newest_idx + 1;
            time_ring[newest_idx] = t;
            value_ring[newest_idx] = v;
            fill++;
            upd = 1;
        end
        r.value = value_ring[oldest_idx];
        if (upd && (t - time_ring[oldest_idx]) >= lag_ticks) begin
            target = t - lag_ticks;
            while (oldest_idx != newest_idx &&
                   (t - time_ring[6'(oldest_idx + 1)]) >= lag_ticks) begin
                oldest_idx = oldest_idx + 1;
                fill--;
            end
            r.value = value_ring[oldest_idx];
            if (oldest_idx != newest_idx && target > time_ring[oldest_idx]) begin
                succ = oldest_idx + 1;
                t0   = time_ring[oldest_idx];
                num  = {32'd0, 32'(target - t0)};
                den  = {32'd0, 32'(time_ring[succ] - t0)};
                if (den != 0 && num < den) begin
                    v0  = longint'($signed(value_ring[oldest_idx]));
                    v1  = longint'($signed(value_ring[succ]));
                    dv  = v1 - v0;
                    mag = (dv < 0) ? 64'(-dv) : 64'(dv);
                    q   = (mag * num) / den;
                    r.value  = (dv < 0) ? 32'(v0 - longint'(q)) : 32'(v0 + longint'(q));
                    r.interp = 1;
                end
            end
        end
        pending_q.push_back(r);
    endfunction

    function void check_result(bit [31:0] value, bit [1:0] flags);
        lag_result_t e;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected transfer value=%h flags=%b", $time, value, flags);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        n_checked++;
        if (e.interp) n_interp++;
        if (e.ovf) n_ovf++;
        if (value !== e.value) begin
            $display("%0t: lagged_value expected %h actual %h", $time, e.value, value);
            errors++;
        end
        if (flags[0] !== e.interp) begin
            $display("%0t: interpolated expected %b actual %b", $time, e.interp, flags[0]);
            errors++;
        end
        if (flags[1] !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf, flags[1]);
            errors++;
        end
    endfunction
endclass

module timestamped_lag_line_interp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 200;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_s_axis_tvalid = 0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;  // current_time, sample_value
    logic        i_s_axis_tuser = 0;   // new_run
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 0;
    logic [31:0] o_m_axis_tdata;       // lagged_value
    logic [1:0]  o_m_axis_tuser;       // interpolated, overflow

    lag_line_scoreboard sb = new();
    int        tx_idle = 0;
    int        rx_idle = 0;
    bit        hold_req = 0;
    int        quiet_cycles = 0;
    int        n_items = 0;
    bit [31:0] t_now = 0;

    timestamped_lag_line_interp #(.RING_DEPTH(64)) dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_input(i_s_axis_tdata[31:0], i_s_axis_tdata[63:32], i_s_axis_tuser);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
            end
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending());
            $display("timestamped_lag_line_interp test failed");
            $finish;
        end
    end

    task automatic send(bit [31:0] t, bit [31:0] v, bit fresh);
        while ($urandom_range(99) < tx_idle) begin
            i_s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= {v, t};
        i_s_axis_tuser  <= fresh;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_lag(bit [31:0] lag);
        drain();
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= lag;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.lag_ticks = lag;
    endtask

    task automatic random_items(int count);
        int  sel;
        bit  fresh;
        for (int k = 0; k < count; k++) begin
            sel   = $urandom_range(99);
            fresh = 0;
            if (sel < 4) begin
                fresh = 1;
                t_now = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1000);
            end else if (sel < 7) begin
                t_now = t_now - $urandom_range(1, 20);
            end else if (sel < 20) begin
                // same time: overwrite newest
            end else if (sel < 90) begin
                t_now = t_now + $urandom_range(1, 8);
            end else begin
                t_now = t_now + $urandom_range(9, 300);
            end
            send(t_now, $urandom, fresh);
        end
    endtask

    function automatic bit [31:0] pick_lag(int b);
        case (b % 5)
            0: return 0;
            1: return $urandom_range(1, 20);
            2: return $urandom_range(20, 400);
            3: return $urandom_range(1, 3);
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // lag 0, extremes of value and time
        send(32'd0, 32'h7FFF_FFFF, 1);
        send(32'd0, 32'h8000_0000, 0);
        send(32'd10, 32'h0000_0000, 0);
        send(32'd5, 32'hFFFF_FFFF, 0);
        send(32'hFFFF_FFFF, 32'h0001_0000, 0);
        send(32'hFFFF_FFFF, 32'h1234_5678, 0);
        send(32'd3, 32'h5555_5555, 0);

        write_lag(32'd5);
        send(32'd100, 32'h8000_0000, 1);
        send(32'd103, 32'h7FFF_FFFF, 0);
        send(32'd107, 32'h0000_0001, 0);
        send(32'd107, 32'hFFFF_0000, 0);
        send(32'd110, 32'h7FFF_FFFF, 0);
        send(32'd200, 32'h8000_0000, 0);
        send(32'd150, 32'h1111_1111, 0);
        send(32'd203, 32'hAAAA_AAAA, 0);
        send(32'hFFFF_FFF0, 32'h0000_0002, 1);
        send(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);

        write_lag(32'hFFFF_FFFF);
        send(32'd0, 32'h0, 1);
        send(32'hFFFF_FFFF, 32'h7FFF_0000, 0);

        // ring fills up with nothing old enough to discard
        for (int k = 0; k < 80; k++)
            send(32'(k * 3 + 1), $urandom, k == 0);

        for (int p = 0; p < 3; p++) begin
            tx_idle = (p == 0) ? 6 : (p == 1) ? 85 : 0;
            rx_idle = (p == 0) ? 85 : (p == 1) ? 6 : 0;
            for (int b = 0; b < 3; b++) begin
                write_lag(pick_lag(p * 3 + b));
                if (p == 0 && b == 1)
                    hold_req = 1;
                random_items(150);
            end
        end

        write_lag($urandom);
        random_items(40);

        drain();
        $display("%0d transfers in, %0d results checked (%0d interpolated, %0d overflow)",
                 n_items, sb.n_checked, sb.n_interp, sb.n_ovf);
        $display("lags from 0 to full scale, ring overflow, time reversal and new runs covered");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("timestamped_lag_line_interp test passed");
        end else begin
            $display("timestamped_lag_line_interp test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
